// ===== src/drs_pkg.sv =====
// ----------------------------------------------------------------------------
// drs_pkg
// Shared types and constants for the dead-reckoning step block.
// ----------------------------------------------------------------------------
package drs_pkg;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 35;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // sine polynomial coefficients, Q30
    localparam logic [31:0] SIN_A = 32'd1686629713;
    localparam logic [31:0] SIN_B = 32'd693598671;
    localparam logic [31:0] SIN_C = 32'd85569278;
    localparam logic [31:0] SIN_D = 32'd5027044;

    // 9.806 in Q16
    localparam logic [31:0] GRAV_Q16 = 32'd642646;

    localparam logic [46:0] DIST_MAX = {47{1'b1}};
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    typedef struct packed {
        logic [1:0]  quad;
        logic [30:0] x;
    } sin_seed_t;

    // fold a 32-bit phase into its quadrant
    function automatic sin_seed_t sin_seed(input logic [31:0] phase);
        sin_seed_t s;
        s.quad = phase[31:30];
        s.x    = phase[30] ? (31'h4000_0000 - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
        return s;
    endfunction

endpackage

// ===== src/drs_mul.sv =====
// ----------------------------------------------------------------------------
// drs_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module drs_mul (
    input  logic                                 clk,
    input  logic signed [drs_pkg::MUL_A_W-1:0]   mul_a,
    input  logic signed [drs_pkg::MUL_B_W-1:0]   mul_b,
    output logic signed [drs_pkg::PROD_W-1:0]    prod
);
    import drs_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    assign prod = prod_reg;

endmodule

// ===== src/dead_reckoning_step.sv =====
// ----------------------------------------------------------------------------
// dead_reckoning_step
// Gravity-corrected forward acceleration, velocity, distance and x/y position
// from one motion sample, computed on one shared multiplier.
// ----------------------------------------------------------------------------
// channel   direction  handshake               beat contents
// in        input      in_valid / in_stall     accel_forward, roll_angle, yaw_angle
// out       output     out_valid / out_stall   pos_x, pos_y, speed, distance,
//                                              forward_accel
// cfg       input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// one sample runs as 20 products on the shared multiplier (roll sine of five
// products, acceleration, gain and step, then yaw sine and cosine of five
// products each and the two position products), then a load into the output
// register; a new sample is taken only once the previous result is loaded.
// in_stall is high from accept until the result is loaded into the output
// register; a stalled result holds there while the next sample is taken, and
// the following result waits in the load state with in_stall still high.
// reset clears control and tracking state and restores the register defaults.
// ----------------------------------------------------------------------------
module dead_reckoning_step #(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [15:0]            accel_forward,
    input  logic signed [ANGLE_BITS-1:0]  roll_angle,
    input  logic signed [ANGLE_BITS-1:0]  yaw_angle,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [47:0]            pos_x,
    output logic signed [47:0]            pos_y,
    output logic [31:0]                   speed,
    output logic [46:0]                   distance,
    output logic signed [31:0]            forward_accel,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [2:0]                    cfg_index,
    input  logic [15:0]                   cfg_data
);
    import drs_pkg::*;

    localparam int ACC_SHIFT = 46 - FRAC_BITS;
    localparam int PAD_BITS  = 32 - ANGLE_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [3:0] OP_SX2  = 4'd0;
    localparam logic [3:0] OP_SD   = 4'd1;
    localparam logic [3:0] OP_SC   = 4'd2;
    localparam logic [3:0] OP_SB   = 4'd3;
    localparam logic [3:0] OP_SA   = 4'd4;
    localparam logic [3:0] OP_ACC  = 4'd5;
    localparam logic [3:0] OP_GAIN = 4'd6;
    localparam logic [3:0] OP_STEP = 4'd7;
    localparam logic [3:0] OP_POSX = 4'd8;
    localparam logic [3:0] OP_POSY = 4'd9;

    localparam logic [1:0] SEL_ROLL = 2'd0;
    localparam logic [1:0] SEL_YAW  = 2'd1;
    localparam logic [1:0] SEL_COS  = 2'd2;

    localparam logic [1:0] GM_NONE = 2'd0;
    localparam logic [1:0] GM_UP   = 2'd1;
    localparam logic [1:0] GM_DOWN = 2'd2;

    localparam logic [2:0] REG_RISE  = 3'd0;
    localparam logic [2:0] REG_STILL = 3'd1;
    localparam logic [2:0] REG_ACCEL = 3'd2;
    localparam logic [2:0] REG_DECEL = 3'd3;
    localparam logic [2:0] REG_STEP  = 3'd4;

    logic [1:0]  state_reg, state_next;
    logic [3:0]  op_reg, op_next;
    logic        ph_reg, ph_next;
    logic [1:0]  sel_reg, sel_next;
    logic [1:0]  gmode_reg, gmode_next;
    logic        still_reg, still_next;

    logic [15:0] rise_reg, still_thr_reg, accel_gain_reg, decel_gain_reg, step_gain_reg;

    logic signed [15:0]           count_reg, count_next;
    logic [ANGLE_BITS-1:0]        yaw_reg, yaw_next;
    logic [1:0]                   quad_reg, quad_next;
    logic [30:0]                  x_reg, x_next;
    logic [30:0]                  x2_reg, x2_next;
    logic [31:0]                  t_reg, t_next;
    logic signed [MUL_A_W-1:0]    diff_reg, diff_next;
    logic signed [31:0]           a_reg, a_next;
    logic signed [31:0]           last_reg, last_next;
    logic [31:0]                  vel_reg, vel_next;
    logic [46:0]                  dist_reg, dist_next;
    logic [31:0]                  step_reg, step_next;
    logic signed [32:0]           sin_reg, sin_next;
    logic signed [32:0]           cos_reg, cos_next;
    logic signed [47:0]           east_reg, east_next;
    logic signed [47:0]           north_reg, north_next;

    logic                         out_valid_reg, out_valid_next;
    logic signed [47:0]           ox_reg, ox_next, oy_reg, oy_next;
    logic [31:0]                  ospeed_reg, ospeed_next;
    logic [46:0]                  odist_reg, odist_next;
    logic signed [31:0]           oacc_reg, oacc_next;

    logic signed [MUL_A_W-1:0]    mul_a;
    logic signed [MUL_B_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]     prod;

    // derived values from the registered product
    logic [32:0]                  s_mag;
    logic signed [32:0]           s_val;
    logic signed [PROD_W-1:0]     acc_sh;
    logic signed [31:0]           a_sat;
    logic signed [PROD_W-1:0]     pos_sh;
    logic signed [49:0]           pos_sum;
    logic signed [47:0]           pos_sat;
    logic signed [32:0]           a_diff;
    logic [32:0]                  a_abs;
    logic [32:0]                  vel_up;
    logic [31:0]                  dec;
    logic [31:0]                  vel_rule;
    logic [31:0]                  st_raw;
    logic [46:0]                  room;
    logic [31:0]                  st_eff;
    sin_seed_t                    seed_roll, seed_yaw, seed_cos;

    drs_mul u_mul (
        .clk   (clk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    assign seed_roll = sin_seed({roll_angle, {PAD_BITS{1'b0}}});
    assign seed_yaw  = sin_seed({yaw_reg, {PAD_BITS{1'b0}}});
    assign seed_cos  = sin_seed({yaw_reg, {PAD_BITS{1'b0}}} + QUARTER_TURN);

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (op_reg)
            OP_SX2:
            begin
                mul_a = {4'b0, x_reg};
                mul_b = {2'b0, x_reg};
            end
            OP_SD:
            begin
                mul_a = {3'b0, SIN_D};
                mul_b = {2'b0, x2_reg};
            end
            OP_SC, OP_SB:
            begin
                mul_a = {3'b0, t_reg};
                mul_b = {2'b0, x2_reg};
            end
            OP_SA:
            begin
                mul_a = {3'b0, t_reg};
                mul_b = {2'b0, x_reg};
            end
            OP_ACC:
            begin
                mul_a = diff_reg;
                mul_b = {1'b0, GRAV_Q16};
            end
            OP_GAIN:
            begin
                mul_a = (gmode_reg == GM_UP) ? {19'b0, accel_gain_reg} : {19'b0, decel_gain_reg};
                mul_b = (gmode_reg == GM_UP) ? {a_reg[31], a_reg} : -{a_reg[31], a_reg};
            end
            OP_STEP:
            begin
                mul_a = {19'b0, step_gain_reg};
                mul_b = {1'b0, vel_reg};
            end
            OP_POSX:
            begin
                mul_a = {3'b0, step_reg};
                mul_b = sin_reg;
            end
            OP_POSY:
            begin
                mul_a = {3'b0, step_reg};
                mul_b = cos_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        s_mag  = prod[62:30];
        s_val  = quad_reg[1] ? -$signed(s_mag) : $signed(s_mag);

        acc_sh = prod >>> ACC_SHIFT;
        if (acc_sh[PROD_W-1:31] == {(PROD_W-31){acc_sh[PROD_W-1]}})
            a_sat = acc_sh[31:0];
        else
            a_sat = acc_sh[PROD_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;

        pos_sh  = prod >>> 30;
        pos_sum = (op_reg == OP_POSX) ? {{2{east_reg[47]}}, east_reg} : {{2{north_reg[47]}}, north_reg};
        pos_sum = pos_sum + pos_sh[49:0];
        if (pos_sum[49:47] == {3{pos_sum[47]}})
            pos_sat = pos_sum[47:0];
        else
            pos_sat = pos_sum[49] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};

        a_diff = {last_reg[31], last_reg} - {a_reg[31], a_reg};
        a_abs  = a_diff[32] ? 33'(-a_diff) : 33'(a_diff);

        vel_up = {1'b0, vel_reg} + {1'b0, prod[47:16]};
        dec    = prod[47:16];
        unique case (gmode_reg)
            GM_UP:   vel_rule = vel_up[32] ? 32'hffff_ffff : vel_up[31:0];
            GM_DOWN: vel_rule = (vel_reg > dec) ? (vel_reg - dec) : 32'd0;
            default: vel_rule = vel_reg;
        endcase

        st_raw = prod[47:16];
        room   = DIST_MAX - dist_reg;
        st_eff = ({15'b0, st_raw} > room) ? room[31:0] : st_raw;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        ph_next        = ph_reg;
        sel_next       = sel_reg;
        gmode_next     = gmode_reg;
        still_next     = still_reg;
        count_next     = count_reg;
        yaw_next       = yaw_reg;
        quad_next      = quad_reg;
        x_next         = x_reg;
        x2_next        = x2_reg;
        t_next         = t_reg;
        diff_next      = diff_reg;
        a_next         = a_reg;
        last_next      = last_reg;
        vel_next       = vel_reg;
        dist_next      = dist_reg;
        step_next      = step_reg;
        sin_next       = sin_reg;
        cos_next       = cos_reg;
        east_next      = east_reg;
        north_next     = north_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        ospeed_next    = ospeed_reg;
        odist_next     = odist_reg;
        oacc_next      = oacc_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    count_next = accel_forward;
                    yaw_next   = yaw_angle;
                    quad_next  = seed_roll.quad;
                    x_next     = seed_roll.x;
                    sel_next   = SEL_ROLL;
                    op_next    = OP_SX2;
                    ph_next    = 1'b0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!ph_reg)
                begin
                    // issue half: product lands at this edge
                    ph_next = 1'b1;
                    if (op_reg == OP_GAIN)
                        still_next = a_abs < {17'b0, still_thr_reg};
                end
                else
                begin
                    ph_next = 1'b0;
                    unique case (op_reg)
                        OP_SX2:
                        begin
                            x2_next = prod[60:30];
                            op_next = OP_SD;
                        end
                        OP_SD:
                        begin
                            t_next  = SIN_C - prod[61:30];
                            op_next = OP_SC;
                        end
                        OP_SC:
                        begin
                            t_next  = SIN_B - prod[61:30];
                            op_next = OP_SB;
                        end
                        OP_SB:
                        begin
                            t_next  = SIN_A - prod[61:30];
                            op_next = OP_SA;
                        end
                        OP_SA:
                        begin
                            unique case (sel_reg)
                                SEL_ROLL:
                                begin
                                    diff_next = {{2{count_reg[15]}}, count_reg, 17'b0}
                                                - {{2{s_val[32]}}, s_val};
                                    op_next   = OP_ACC;
                                end
                                SEL_YAW:
                                begin
                                    sin_next  = s_val;
                                    quad_next = seed_cos.quad;
                                    x_next    = seed_cos.x;
                                    sel_next  = SEL_COS;
                                    op_next   = OP_SX2;
                                end
                                default:
                                begin
                                    cos_next = s_val;
                                    op_next  = OP_POSX;
                                end
                            endcase
                        end
                        OP_ACC:
                        begin
                            a_next = a_sat;
                            if (!a_sat[31] && (a_sat[30:0] > {15'b0, rise_reg}))
                                gmode_next = GM_UP;
                            else if (a_sat[31] && (vel_reg != 32'd0))
                                gmode_next = GM_DOWN;
                            else
                                gmode_next = GM_NONE;
                            op_next = OP_GAIN;
                        end
                        OP_GAIN:
                        begin
                            vel_next = still_reg ? 32'd0 : vel_rule;
                            op_next  = OP_STEP;
                        end
                        OP_STEP:
                        begin
                            step_next = st_eff;
                            dist_next = dist_reg + {15'b0, st_eff};
                            quad_next = seed_yaw.quad;
                            x_next    = seed_yaw.x;
                            sel_next  = SEL_YAW;
                            op_next   = OP_SX2;
                        end
                        OP_POSX:
                        begin
                            east_next = pos_sat;
                            op_next   = OP_POSY;
                        end
                        OP_POSY:
                        begin
                            north_next = pos_sat;
                            last_next  = a_reg;
                            state_next = ST_DONE;
                        end
                        default:
                        begin
                            op_next = OP_SX2;
                        end
                    endcase
                end
            end
            ST_DONE:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    ox_next        = east_reg;
                    oy_next        = north_reg;
                    ospeed_next    = vel_reg;
                    odist_next     = dist_reg;
                    oacc_next      = a_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= OP_SX2;
            ph_reg         <= 1'b0;
            sel_reg        <= SEL_ROLL;
            gmode_reg      <= GM_NONE;
            still_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_reg       <= '0;
            vel_reg        <= '0;
            dist_reg       <= '0;
            east_reg       <= '0;
            north_reg      <= '0;
            rise_reg       <= 16'd13107;
            still_thr_reg  <= 16'd590;
            accel_gain_reg <= 16'd1966;
            decel_gain_reg <= 16'd2294;
            step_gain_reg  <= 16'd1966;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            ph_reg        <= ph_next;
            sel_reg       <= sel_next;
            gmode_reg     <= gmode_next;
            still_reg     <= still_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
            vel_reg       <= vel_next;
            dist_reg      <= dist_next;
            east_reg      <= east_next;
            north_reg     <= north_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_RISE:  rise_reg       <= cfg_data;
                    REG_STILL: still_thr_reg  <= cfg_data;
                    REG_ACCEL: accel_gain_reg <= cfg_data;
                    REG_DECEL: decel_gain_reg <= cfg_data;
                    REG_STEP:  step_gain_reg  <= cfg_data;
                    default:   ;
                endcase
            end
        end
    end

    // payload and scratch registers
    always_ff @(posedge clk)
    begin
        count_reg  <= count_next;
        yaw_reg    <= yaw_next;
        quad_reg   <= quad_next;
        x_reg      <= x_next;
        x2_reg     <= x2_next;
        t_reg      <= t_next;
        diff_reg   <= diff_next;
        a_reg      <= a_next;
        step_reg   <= step_next;
        sin_reg    <= sin_next;
        cos_reg    <= cos_next;
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        ospeed_reg <= ospeed_next;
        odist_reg  <= odist_next;
        oacc_reg   <= oacc_next;
    end

    assign in_stall      = (state_reg != ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign pos_x         = ox_reg;
    assign pos_y         = oy_reg;
    assign speed         = ospeed_reg;
    assign distance      = odist_reg;
    assign forward_accel = oacc_reg;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Sends motion samples into dead_reckoning_step, tracks speed, distance and
// position in a local integer model, and compares every output fix field by
// field under varying register settings, idle patterns and output stalls.
// ----------------------------------------------------------------------------
module testbench;

    typedef enum logic [2:0] {
        REG_RISE    = 3'd0,
        REG_STILL   = 3'd1,
        REG_ACCEL   = 3'd2,
        REG_DECEL   = 3'd3,
        REG_STEP    = 3'd4,
        REG_SPARE   = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic signed [47:0] east;
        logic signed [47:0] north;
        logic [31:0]        spd;
        logic [46:0]        travel;
        logic signed [31:0] acc;
    } nav_fix_t;

    localparam longint POS_HI   = (64'sd1 <<< 47) - 1;
    localparam longint POS_LO   = -(64'sd1 <<< 47);
    localparam longint DIST_TOP = (64'sd1 <<< 47) - 1;
    localparam longint VEL_TOP  = 64'sd4294967295;
    localparam longint LIMIT    = 3000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [15:0] accel_forward = '0;
    logic signed [15:0] roll_angle = '0;
    logic signed [15:0] yaw_angle = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic [31:0] speed;
    logic [46:0] distance;
    logic signed [31:0] forward_accel;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // local copy of registers and tracking state
    longint rise_thr, still_thr, gain_up, gain_down, gain_step;
    longint vel, dist_total, prev_acc, east_acc, north_acc;

    nav_fix_t expected_fixes[$];
    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    int errors = 0;
    int samples_sent = 0;
    int fixes_checked = 0;
    int cfg_writes = 0;
    longint cycle_count = 0;

    dead_reckoning_step dut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench failed");
            $finish;
        end
    end

    function automatic longint sine_q30(input logic [31:0] phase);
        longint unsigned f, x, x2, t;
        longint s;
        f = phase[29:0];
        x = phase[30] ? ((64'd1 << 30) - f) : f;
        x2 = (x * x) >> 30;
        t = 64'd85569278 - ((64'd5027044 * x2) >> 30);
        t = 64'd693598671 - ((t * x2) >> 30);
        t = 64'd1686629713 - ((t * x2) >> 30);
        s = longint'((t * x) >> 30);
        return phase[31] ? -s : s;
    endfunction

    function automatic longint clamp_pos(input longint v);
        if (v > POS_HI) return POS_HI;
        if (v < POS_LO) return POS_LO;
        return v;
    endfunction

    // one sample through the tracking model, returns the expected fix
    function automatic nav_fix_t advance_track(input logic signed [15:0] cnt,
                                               input logic [15:0] roll,
                                               input logic [15:0] yaw);
        longint a, d, step, dec;
        logic [31:0] yaw_ph;
        nav_fix_t fx;
        a = ((longint'(cnt) * 131072 - sine_q30({roll, 16'h0})) * 642646) >>> 30;
        if (a > 64'sd2147483647) a = 64'sd2147483647;
        if (a < -64'sd2147483648) a = -64'sd2147483648;
        if (a > rise_thr)
        begin
            vel = vel + ((gain_up * a) >>> 16);
            if (vel > VEL_TOP) vel = VEL_TOP;
        end
        else if (a < 0 && vel > 0)
        begin
            dec = (gain_down * -a) >>> 16;
            vel = (vel > dec) ? vel - dec : 0;
        end
        d = prev_acc - a;
        if (d < 0) d = -d;
        if (d < still_thr) vel = 0;
        step = (gain_step * vel) >>> 16;
        if (step > DIST_TOP - dist_total) step = DIST_TOP - dist_total;
        dist_total = dist_total + step;
        yaw_ph = {yaw, 16'h0};
        east_acc = clamp_pos(east_acc + ((step * sine_q30(yaw_ph)) >>> 30));
        north_acc = clamp_pos(north_acc + ((step * sine_q30(yaw_ph + 32'h4000_0000)) >>> 30));
        prev_acc = a;
        fx.east = east_acc[47:0];
        fx.north = north_acc[47:0];
        fx.spd = vel[31:0];
        fx.travel = dist_total[46:0];
        fx.acc = a[31:0];
        return fx;
    endfunction

    // output side: stall pattern, long hold-off, and checking
    always @(posedge clk)
    begin
        nav_fix_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_fixes.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected fix beat at cycle %0d", cycle_count);
            end
            else
            begin
                want = expected_fixes.pop_front();
                fixes_checked++;
                if (want.east !== pos_x || want.north !== pos_y || want.spd !== speed
                    || want.travel !== distance || want.acc !== forward_accel)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("fix %0d mismatch: exp x=%0d y=%0d v=%0d d=%0d a=%0d",
                                 fixes_checked, want.east, want.north, want.spd,
                                 want.travel, want.acc);
                        $display("    got x=%0d y=%0d v=%0d d=%0d a=%0d",
                                 pos_x, pos_y, speed, distance, forward_accel);
                    end
                end
            end
        end
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    task automatic send_sample(input logic [15:0] cnt, input logic [15:0] roll,
                               input logic [15:0] yaw);
        accel_forward <= cnt;
        roll_angle <= roll;
        yaw_angle <= yaw;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        expected_fixes.push_back(advance_track(cnt, roll, yaw));
        samples_sent++;
        if ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < sender_idle_pct) @(posedge clk);
        end
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (expected_fixes.size() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
        case (idx)
            REG_RISE:  rise_thr = val;
            REG_STILL: still_thr = val;
            REG_ACCEL: gain_up = val;
            REG_DECEL: gain_down = val;
            REG_STEP:  gain_step = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic load_regs(input logic [15:0] r, input logic [15:0] s,
                             input logic [15:0] up, input logic [15:0] dn,
                             input logic [15:0] st);
        drain();
        write_reg(REG_RISE, r);
        write_reg(REG_STILL, s);
        write_reg(REG_ACCEL, up);
        write_reg(REG_DECEL, dn);
        write_reg(REG_STEP, st);
    endtask

    // mostly plausible driving samples, some full-range noise and repeats
    task automatic random_samples(input int n);
        logic [15:0] c, r, y;
        int pick;
        c = '0;
        r = '0;
        y = '0;
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                c = 16'($urandom_range(0, 20000)) - 16'd6000;
                r = 16'($urandom_range(0, 2000)) - 16'd1000;
                if ($urandom_range(0, 9) == 0) y = 16'($urandom);
                else y = y + 16'($urandom_range(0, 400)) - 16'd200;
            end
            else if (pick < 85)
            begin
                c = 16'($urandom);
                r = 16'($urandom);
                y = 16'($urandom);
            end
            else if (pick < 95)
                c = c + 16'($urandom_range(0, 4)) - 16'd2;
            else
                c = -c;
            send_sample(c, r, y);
        end
    endtask

    task automatic test_directed;
        send_sample(16'd0, 16'd0, 16'd0);             // first sample vs zero
        send_sample(16'h7fff, 16'd0, 16'd0);
        send_sample(16'h7fff, 16'h8000, 16'h4000);
        send_sample(16'h7fff, 16'h7fff, 16'hc000);
        send_sample(16'h7fff, 16'h7fff, 16'hc000);    // repeat: standstill
        send_sample(16'd16000, 16'h4000, 16'h8000);
        send_sample(16'd20000, 16'hc000, 16'h7fff);
        send_sample(16'h8000, 16'd0, 16'h2000);       // hard brake to zero
        send_sample(16'h8000, 16'h4000, 16'h2000);
        send_sample(16'd30000, 16'hc000, 16'hffff);
        send_sample(16'd8192, 16'h0001, 16'h0001);
        send_sample(16'hffff, 16'hffff, 16'h0000);
        send_sample(16'd12000, 16'h2000, 16'h6000);
        send_sample(16'd12001, 16'h2000, 16'ha000);
        send_sample(16'hc000, 16'he000, 16'h1234);
        send_sample(16'd5000, 16'h0000, 16'hedcb);
    endtask

    task automatic test_registers;
        load_regs(16'd0, 16'd0, 16'hffff, 16'hffff, 16'hffff);
        send_sample(16'h7fff, 16'hc000, 16'h3000);
        random_samples(12);
        load_regs(16'hffff, 16'hffff, 16'd0, 16'd0, 16'd0);
        random_samples(12);
        load_regs(16'd100, 16'd1, 16'h8000, 16'h0100, 16'h4000);
        random_samples(12);
        drain();
        write_reg(REG_SPARE, 16'hffff);               // unknown index, ignored
        random_samples(6);
        load_regs(16'd13107, 16'd590, 16'd1966, 16'd2294, 16'd1966);
    endtask

    task automatic test_random_phases;
        sender_idle_pct = 0;  recv_stall_pct = 0;  random_samples(400);
        sender_idle_pct = 46; recv_stall_pct = 0;  random_samples(300);
        sender_idle_pct = 0;  recv_stall_pct = 46; random_samples(300);
        load_regs(16'd2000, 16'd50, 16'd20000, 16'd9000, 16'd30000);
        sender_idle_pct = 21; recv_stall_pct = 21; random_samples(400);
        load_regs(16'd13107, 16'd590, 16'd1966, 16'd2294, 16'd1966);
    endtask

    task automatic test_backpressure;
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 400;
        random_samples(291);
    endtask

    initial
    begin
        rise_thr = 13107; still_thr = 590; gain_up = 1966;
        gain_down = 2294; gain_step = 1966;
        vel = 0; dist_total = 0; prev_acc = 0; east_acc = 0; north_acc = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_registers();
        test_random_phases();
        test_backpressure();
        drain();
        repeat (100) @(posedge clk);
        $display("sent %0d motion samples, checked %0d fixes, %0d register writes",
                 samples_sent, fixes_checked, cfg_writes);
        if (errors == 0 && expected_fixes.size() == 0)
            $display("testbench passed");
        else
        begin
            $display("%0d mismatches, %0d fixes missing", errors, expected_fixes.size());
            $display("testbench failed");
        end
        $finish;
    end

endmodule
